FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

    // Width of the payload length counter (16 to 64).
    localparam int LENGTH_BITS = 64;

    typedef logic [LENGTH_BITS-1:0] len_t;

    localparam logic [7:0] FIN_BIT     = 8'h80;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] CTRL_BIT    = 8'h08;
    localparam logic [7:0] LEN_CODE_M  = 8'h7F;
    localparam logic [6:0] LEN_CODE16  = 7'd126;
    localparam logic [6:0] LEN_CODE64  = 7'd127;
    localparam int         CTRL_MAXLEN = 125;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_KEY     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_HALTED  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_control;
        logic       frame_end;
        logic       message_end;
        logic       protocol_error;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/websocket_frame_deframer.sv
`default_nettype none
// Channel   Direction  Handshake            Beat contents
// input     in         in_valid/in_ready    stream_byte
// result    out        out_valid/out_ready  payload_byte, is_control, frame_end,
//                                           message_end, protocol_error
//
// One stream byte is taken per cycle while in_ready is high; the single result
// register between parser and output gives its payload byte in the next cycle.
// Header bytes give no beat but on a control length error; no later byte does.
// Reset (rst_n low, asynchronous) returns the parser to the first header byte.
// While the result register holds a beat and out_ready is low, in_ready drops.
module websocket_frame_deframer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] stream_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      payload_byte,
    output logic            is_control,
    output logic            frame_end,
    output logic            message_end,
    output logic            protocol_error
);
    import wsd_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic        fin_reg,    fin_next;
    logic        ctl_reg,    ctl_next;
    logic        mask_reg,   mask_next;
    logic [3:0]  left_reg,   left_next;
    len_t        cnt_reg,    cnt_next;
    logic        ovf_reg,    ovf_next;   // declared length overflowed the counter
    logic [31:0] key_reg,    key_next;
    logic [1:0]  mphase_reg, mphase_next;

    logic        accept;
    logic        can_load;
    logic        emit;
    result_t     res;
    result_t     out_data;

    // Header-finish helpers.
    logic        hdr_done;
    len_t        hdr_len;
    logic        hdr_ovf;
    logic        len_done;
    logic [3:0]  left_dec;
    logic        last_byte;
    logic [7:0]  key_byte;

    assign accept    = in_valid && in_ready;
    assign in_ready  = can_load;
    assign left_dec  = left_reg - 4'd1;
    assign last_byte = (cnt_reg <= len_t'(1));
    // Key byte for this phase: the first received key byte sits in bits 31..24.
    assign key_byte  = key_reg[{~mphase_reg, 3'b000} +: 8];

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        ctl_next    = ctl_reg;
        mask_next   = mask_reg;
        left_next   = left_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        key_next    = key_reg;
        mphase_next = mphase_reg;
        emit        = 1'b0;
        res         = '0;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        hdr_len     = cnt_reg;
        hdr_ovf     = ovf_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next   = (stream_byte & FIN_BIT) != 8'h00;
                    ctl_next   = (stream_byte & CTRL_BIT) != 8'h00;
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_next = (stream_byte & MASK_BIT) != 8'h00;
                    key_next  = '0;
                    ovf_next  = 1'b0;
                    if (stream_byte[6:0] == LEN_CODE16)
                    begin
                        cnt_next   = '0;
                        left_next  = EXT16_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else if (stream_byte[6:0] == LEN_CODE64)
                    begin
                        cnt_next   = '0;
                        left_next  = EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        hdr_len  = len_t'(stream_byte & LEN_CODE_M);
                        hdr_ovf  = 1'b0;
                        cnt_next = hdr_len;
                        len_done = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    // Shift in big-endian; remember any bits pushed off the top.
                    hdr_len   = {cnt_reg[LENGTH_BITS-9:0], stream_byte};
                    hdr_ovf   = ovf_reg || (cnt_reg[LENGTH_BITS-1 -: 8] != 8'h00);
                    cnt_next  = hdr_len;
                    ovf_next  = hdr_ovf;
                    left_next = left_dec;
                    len_done  = (left_dec == 4'd0);
                end
                PH_KEY:
                begin
                    key_next  = {key_reg[23:0], stream_byte};
                    left_next = left_dec;
                    hdr_done  = (left_dec == 4'd0);
                end
                PH_PAYLOAD:
                begin
                    emit               = 1'b1;
                    res.payload_byte   = stream_byte ^ key_byte;
                    res.is_control     = ctl_reg;
                    res.frame_end      = last_byte;
                    res.message_end    = last_byte && fin_reg;
                    res.protocol_error = 1'b0;
                    mphase_next        = mphase_reg + 2'd1;
                    if (last_byte)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - len_t'(1);
                    end
                end
                PH_HALTED:
                begin
                    // Drop every byte until reset.
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // Length complete: fetch the key when masked, else finish now.
            if (len_done)
            begin
                if (mask_next)
                begin
                    left_next  = KEY_BYTES;
                    phase_next = PH_KEY;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done)
            begin
                mphase_next = 2'd0;
                left_next   = 4'd0;
                if (ctl_next && (hdr_ovf || (hdr_len > len_t'(CTRL_MAXLEN))))
                begin
                    phase_next         = PH_HALTED;
                    cnt_next           = '0;
                    emit               = 1'b1;
                    res.payload_byte   = 8'h00;
                    res.is_control     = 1'b1;
                    res.frame_end      = 1'b0;
                    res.message_end    = 1'b0;
                    res.protocol_error = 1'b1;
                end
                else
                begin
                    // Saturate a length that does not fit the counter.
                    cnt_next   = hdr_ovf ? '1 : hdr_len;
                    phase_next = (!hdr_ovf && (hdr_len == '0)) ? PH_HDR0 : PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            ctl_reg    <= 1'b0;
            mask_reg   <= 1'b0;
            left_reg   <= 4'd0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            key_reg    <= '0;
            mphase_reg <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            ctl_reg    <= ctl_next;
            mask_reg   <= mask_next;
            left_reg   <= left_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            key_reg    <= key_next;
            mphase_reg <= mphase_next;
        end
    end

    // Result register: holds one beat; out_ready reaches in_ready combinationally.
    wsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign payload_byte   = out_data.payload_byte;
    assign is_control     = out_data.is_control;
    assign frame_end      = out_data.frame_end;
    assign message_end    = out_data.message_end;
    assign protocol_error = out_data.protocol_error;

    `include "assert_macros.svh"

    `ASSERT_IMP(a_payload_nonzero, phase_reg == PH_PAYLOAD, cnt_reg != '0, "payload phase with empty count")
    `ASSERT_IMP(a_hdr_left, (phase_reg == PH_EXTLEN) || (phase_reg == PH_KEY), left_reg != 4'd0, "header phase with no bytes due")
    `ASSERT_NEXT(a_err_halts, emit && res.protocol_error, phase_reg == PH_HALTED, "error beat without halting")
    `ASSERT_IMP(a_halt_silent, phase_reg == PH_HALTED, !emit, "beat produced while halted")

endmodule
`default_nettype wire

FILE: rtl/wsd_out_buf.sv
`default_nettype none
module wsd_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire wsd_pkg::result_t load_data,
    output logic                  can_load,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wsd_pkg::result_t      out_data
);
    import wsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Take a new beat when none is held or the held one leaves in the same cycle.
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_hold_stalled, valid_reg && !out_ready && !load, valid_reg && $stable(data_reg), "held beat changed while stalled")
    `ASSERT_IMP(a_load_has_room, load, can_load, "beat loaded over a held result")

endmodule
`default_nettype wire
